>>> design/pwzls_pkg.sv
`timescale 1ns / 1ps

package pwzls_pkg;

   localparam int ZONES_DEF = 7;
   localparam int PIN_W     = 14;

   // commands
   localparam logic [2:0] CMD_SET    = 3'd0;
   localparam logic [2:0] CMD_QUERY  = 3'd1;
   localparam logic [2:0] CMD_SHED   = 3'd2;
   localparam logic [2:0] CMD_UNSHED = 3'd3;
   localparam logic [2:0] CMD_ROTATE = 3'd4;

   // zone modes
   localparam logic [2:0] MODE_COMFORT = 3'd0;
   localparam logic [2:0] MODE_ECO     = 3'd1;
   localparam logic [2:0] MODE_FROST   = 3'd2;
   localparam logic [2:0] MODE_OFF     = 3'd3;
   localparam logic [2:0] MODE_SHED    = 3'd4;

   // result status
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_HELD   = 2'd2;

   typedef struct packed {
      logic [2:0] command;
      logic [3:0] zone;
      logic [2:0] mode;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [2:0]       mode_read;
      logic [PIN_W-1:0] pin_drive;
      logic [2:0]       shed_count;
      logic [2:0]       oldest_shed;
   } rsp_type;

   typedef struct packed {
      logic load_in;
      logic exec;
      logic shed2;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic rot_go;
   } dp_stat_type;

   // first wire in bit 0, second wire in bit 1
   function automatic logic [1:0] wire_pattern(input logic [2:0] code);
      logic [1:0] pat;
      unique case (code)
         MODE_COMFORT: pat = 2'b00;
         MODE_ECO:     pat = 2'b11;
         MODE_OFF:     pat = 2'b10;
         default:      pat = 2'b01;
      endcase
      return pat;
   endfunction

endpackage

>>> design/pilot_wire_zone_load_shedder.sv
`timescale 1ns / 1ps

// an accepted word runs the exec state, then the rot state if it rotates, then done, which loads rsp
// the sequencer runs one command at a time; req_stall is high from accept until done loads rsp
// the rot state of a rotate is the shed step that follows its unshed on the same zone state
// a stalled previous rsp word holds the last step until that word leaves
// reset: every zone active and requested frost guard, no zone shed, oldest shed zone one,
// rsp_valid low, ready for a word in the first cycle after reset
module pilot_wire_zone_load_shedder #(
   parameter int ZONES = pwzls_pkg::ZONES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pwzls_pkg::req_type req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pwzls_pkg::rsp_type rsp
);

   pwzls_pkg::ctl_cmd_type cmd;
   pwzls_pkg::dp_stat_type stat;

   pwzls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pwzls_dp #(
      .ZONES (ZONES)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp)
   );

   a_shed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.shed_count <= 3'(ZONES)))
      else $error("shed count above zone count");

   a_oldest_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.oldest_shed != 3'd0 && rsp.oldest_shed <= 3'(ZONES)))
      else $error("oldest shed zone out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted a second word while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status != 2'd3))
      else $error("undefined status code");

endmodule

>>> design/pwzls_ctrl.sv
`timescale 1ns / 1ps

module pwzls_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pwzls_pkg::dp_stat_type stat,
   output pwzls_pkg::ctl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_ROT  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.rot_go ? S_ROT : S_DONE;
         end
         S_ROT: begin
            cmd.shed2 = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/pwzls_dp.sv
`timescale 1ns / 1ps

module pwzls_dp #(
   parameter int ZONES = pwzls_pkg::ZONES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pwzls_pkg::req_type     req,
   input  pwzls_pkg::ctl_cmd_type cmd,
   output pwzls_pkg::dp_stat_type stat,
   output pwzls_pkg::rsp_type     rsp
);

   localparam int         IW = $clog2(ZONES);
   localparam logic [2:0] ZN = 3'(ZONES);
   localparam int         PIN_W_L = pwzls_pkg::PIN_W;

   pwzls_pkg::req_type in_ff;
   pwzls_pkg::rsp_type rsp_ff;

   logic [2:0] act_ff  [ZONES];
   logic [1:0] reqm_ff [ZONES];
   logic [1:0] drv_ff  [ZONES];
   logic [2:0] level_ff, level_in;
   logic [2:0] oldest_ff, oldest_in;
   logic [1:0] status_ff, status_in;
   logic [2:0] mread_ff, mread_in;

   logic          zone_ok, rot_ok;
   logic [IW-1:0] zi, oi, si;
   logic [3:0]    sum;
   logic          ap_en, rq_en, do_shed, do_unshed;
   logic [IW-1:0] ap_idx;
   logic [2:0]    ap_code;
   logic [PIN_W_L-1:0] pin;

   assign zone_ok = (in_ff.zone != 4'd0) && (in_ff.zone <= {1'b0, ZN});
   assign zi      = IW'(in_ff.zone[2:0] - 3'd1);
   assign oi      = IW'(oldest_ff - 3'd1);
   // next zone after the shed run, wrapping once at most
   assign sum     = {1'b0, oldest_ff - 3'd1} + {1'b0, level_ff};
   assign si      = (sum >= {1'b0, ZN}) ? IW'(sum - {1'b0, ZN}) : IW'(sum);
   assign rot_ok  = (level_ff != 3'd0) && (level_ff < ZN);

   assign stat.rot_go = (in_ff.command == pwzls_pkg::CMD_ROTATE) && rot_ok;

   always_comb begin
      ap_en     = 1'b0;
      ap_idx    = zi;
      ap_code   = pwzls_pkg::MODE_FROST;
      rq_en     = 1'b0;
      do_shed   = cmd.shed2;
      do_unshed = 1'b0;
      level_in  = level_ff;
      oldest_in = oldest_ff;
      status_in = status_ff;
      mread_in  = mread_ff;
      if (cmd.exec) begin
         status_in = pwzls_pkg::ST_DONE;
         mread_in  = pwzls_pkg::MODE_COMFORT;
         unique case (in_ff.command)
            pwzls_pkg::CMD_SET: begin
               if (!zone_ok || in_ff.mode > pwzls_pkg::MODE_OFF) begin
                  status_in = pwzls_pkg::ST_REJECT;
               end else begin
                  rq_en = 1'b1;
                  if (act_ff[zi] == pwzls_pkg::MODE_SHED) begin
                     status_in = pwzls_pkg::ST_HELD;
                  end else begin
                     ap_en   = 1'b1;
                     ap_code = in_ff.mode;
                  end
               end
            end
            pwzls_pkg::CMD_QUERY: begin
               if (!zone_ok) begin
                  status_in = pwzls_pkg::ST_REJECT;
               end else begin
                  mread_in = act_ff[zi];
               end
            end
            pwzls_pkg::CMD_SHED:   do_shed   = 1'b1;
            pwzls_pkg::CMD_UNSHED: do_unshed = 1'b1;
            pwzls_pkg::CMD_ROTATE: do_unshed = rot_ok;
            default:               status_in = pwzls_pkg::ST_REJECT;
         endcase
      end
      if (do_unshed && level_ff != 3'd0) begin
         level_in  = level_ff - 3'd1;
         ap_en     = 1'b1;
         ap_idx    = oi;
         ap_code   = {1'b0, reqm_ff[oi]};
         oldest_in = (oldest_ff == ZN) ? 3'd1 : oldest_ff + 3'd1;
      end
      if (do_shed && level_ff < ZN) begin
         level_in = level_ff + 3'd1;
         ap_en    = 1'b1;
         ap_idx   = si;
         ap_code  = pwzls_pkg::MODE_SHED;
      end
   end

   always_comb begin
      pin = '0;
      for (int z = 0; z < ZONES; z++) begin
         pin[2*z +: 2] = drv_ff[z];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ZONES; i++) begin
            act_ff[i]  <= pwzls_pkg::MODE_FROST;
            reqm_ff[i] <= pwzls_pkg::MODE_FROST[1:0];
            drv_ff[i]  <= pwzls_pkg::wire_pattern(pwzls_pkg::MODE_FROST);
         end
         level_ff  <= 3'd0;
         oldest_ff <= 3'd1;
      end else begin
         if (ap_en) begin
            act_ff[ap_idx] <= ap_code;
            drv_ff[ap_idx] <= pwzls_pkg::wire_pattern(ap_code);
         end
         if (rq_en) begin
            reqm_ff[zi] <= in_ff.mode[1:0];
         end
         level_ff  <= level_in;
         oldest_ff <= oldest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req;
      end
      status_ff <= status_in;
      mread_ff  <= mread_in;
      if (cmd.load_rsp) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.mode_read   <= mread_ff;
         rsp_ff.pin_drive   <= pin;
         rsp_ff.shed_count  <= level_ff;
         rsp_ff.oldest_shed <= oldest_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule
